/* hw/rtl/sha1mh_pkg.sv */
// shared types and constants for the sha-1 message hasher
// used by sha1_message_hasher; depends on nothing else
package sha1mh_pkg;

    // input beat: one optional message byte plus end marker
    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       message_end;
    } in_t;

    // output beat: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        final_word;
    } out_t;

    localparam int unsigned DIGEST_WORDS = 5;
    localparam int unsigned ROUNDS       = 80;
    localparam int unsigned LEN_OFFSET   = 56;

    // initial chaining value h0..h4
    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // round constants, one per group of twenty rounds
    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

/* hw/rtl/sha1_message_hasher.sv */
// Streaming SHA-1 hasher. Each input beat carries at most one message byte and
// an end marker. The beat that completes a 64-byte block holds s_ready low
// while the 80 rounds run on one shared round unit and the chaining add
// follows, then the block returns to idle. Bytes are gathered in a 512-bit
// shift register that also serves as the 16-word message schedule window. On
// the end marker the pad sequencer feeds 0x80, zero bytes and the 8 length
// bytes one per cycle through the same register, pausing while a compression
// runs, and so runs one or two more compressions before five digest words (h0
// first) appear on the result channel; the block accepts nothing until the
// last of them is taken, then restarts with the initial chaining value.
// depends on sha1mh_pkg
module sha1_message_hasher (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sha1mh_pkg::in_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sha1mh_pkg::out_t  m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PS_NONE,
        PS_MARK,
        PS_ZERO,
        PS_LEN,
        PS_DONE
    } pad_t;

    localparam int unsigned IDX_W = $clog2(sha1mh_pkg::DIGEST_WORDS);

    state_t             state_reg, state_next;
    pad_t               pad_reg, pad_next;
    logic [6:0]         round_reg, round_next;
    logic [5:0]         fill_reg, fill_next;
    logic [63:0]        bit_length_reg, bit_length_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic [15:0][31:0]  window_reg, window_next;
    logic [31:0]        chain_reg [sha1mh_pkg::DIGEST_WORDS];
    logic [31:0]        chain_next [sha1mh_pkg::DIGEST_WORDS];
    logic [31:0]        a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]        a_next, b_next, c_next, d_next, e_next;

    logic [519:0]       byte_shift;
    logic [7:0]         shift_byte;
    logic               do_shift;
    logic [7:0]         len_byte;
    logic [31:0]        f_val, k_val, w_new, t_val;
    logic               in_beat;

    assign in_beat = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    // result beat straight from the chaining registers
    always_comb begin
        m_data.digest_word = chain_reg[out_idx_reg];
        m_data.word_number = 3'(out_idx_reg);
        m_data.final_word  = (out_idx_reg == IDX_W'(sha1mh_pkg::DIGEST_WORDS - 1));
    end

    // length byte for fill offsets 56..63, most significant first
    assign len_byte = 8'(bit_length_reg >> {3'(~fill_reg[2:0]), 3'b000});

    // byte entry into the low end of the window
    assign byte_shift = {window_reg, shift_byte};

    // round function and constant by round group
    always_comb begin
        if (round_reg < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1mh_pkg::K_0;
        end else if (round_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1mh_pkg::K_1;
        end else if (round_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1mh_pkg::K_2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1mh_pkg::K_3;
        end
    end

    // schedule expansion: element 15 holds w[t], element 0 the newest word
    always_comb begin
        w_new = window_reg[2] ^ window_reg[7] ^ window_reg[13] ^ window_reg[15];
        w_new = {w_new[30:0], w_new[31]};
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + window_reg[15];
    end

    // sequencer next state
    always_comb begin
        state_next      = state_reg;
        pad_next        = pad_reg;
        round_next      = round_reg;
        fill_next       = fill_reg;
        bit_length_next = bit_length_reg;
        out_idx_next    = out_idx_reg;
        window_next     = window_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        d_next          = d_reg;
        e_next          = e_reg;
        chain_next      = chain_reg;
        shift_byte      = 8'h00;
        do_shift        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (s_data.message_end) begin
                        pad_next = PS_MARK;
                    end
                    if (s_data.byte_present) begin
                        shift_byte      = s_data.message_byte;
                        do_shift        = 1'b1;
                        bit_length_next = bit_length_reg + 64'd8;
                    end else if (s_data.message_end) begin
                        state_next = ST_PAD;
                    end
                    if (s_data.byte_present && !s_data.message_end
                            && fill_reg != 6'd63) begin
                        state_next = ST_IDLE;
                    end else if (s_data.byte_present && fill_reg != 6'd63) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                do_shift = 1'b1;
                case (pad_reg)
                    PS_MARK: begin
                        shift_byte = sha1mh_pkg::PAD_MARK;
                        pad_next   = (fill_reg == 6'(sha1mh_pkg::LEN_OFFSET - 1))
                                     ? PS_LEN : PS_ZERO;
                    end
                    PS_ZERO: begin
                        shift_byte = 8'h00;
                        if (fill_reg == 6'(sha1mh_pkg::LEN_OFFSET - 1)) begin
                            pad_next = PS_LEN;
                        end
                    end
                    PS_LEN: begin
                        shift_byte = len_byte;
                        if (fill_reg == 6'd63) begin
                            pad_next = PS_DONE;
                        end
                    end
                    default: begin
                        do_shift = 1'b0;
                    end
                endcase
            end
            ST_ROUND: begin
                window_next = {window_reg[14:0], w_new};
                a_next      = t_val;
                b_next      = a_reg;
                c_next      = {b_reg[1:0], b_reg[31:2]};
                d_next      = c_reg;
                e_next      = d_reg;
                if (round_reg == 7'(sha1mh_pkg::ROUNDS - 1)) begin
                    round_next = '0;
                    state_next = ST_ADD;
                end else begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_ADD: begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                case (pad_reg)
                    PS_NONE: state_next = ST_IDLE;
                    PS_DONE: state_next = ST_OUT;
                    default: state_next = ST_PAD;
                endcase
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (out_idx_reg == IDX_W'(sha1mh_pkg::DIGEST_WORDS - 1)) begin
                        out_idx_next    = '0;
                        chain_next      = sha1mh_pkg::H_INIT;
                        bit_length_next = '0;
                        fill_next       = '0;
                        pad_next        = PS_NONE;
                        state_next      = ST_IDLE;
                    end else begin
                        out_idx_next = out_idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // byte entry, and start of compression on a full block
        if (do_shift) begin
            window_next = byte_shift[511:0];
            fill_next   = fill_reg + 6'd1;
            if (fill_reg == 6'd63) begin
                state_next = ST_ROUND;
                round_next = '0;
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                e_next     = chain_reg[4];
            end
        end
    end

    // state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pad_reg        <= PS_NONE;
            round_reg      <= '0;
            fill_reg       <= '0;
            bit_length_reg <= '0;
            out_idx_reg    <= '0;
            chain_reg      <= sha1mh_pkg::H_INIT;
        end else begin
            state_reg      <= state_next;
            pad_reg        <= pad_next;
            round_reg      <= round_next;
            fill_reg       <= fill_next;
            bit_length_reg <= bit_length_next;
            out_idx_reg    <= out_idx_next;
            chain_reg      <= chain_next;
        end
        window_reg <= window_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
    end

    // checks on the sequencer
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels active together");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> (round_reg < 7'(sha1mh_pkg::ROUNDS)))
        else $error("round counter out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pad_reg == PS_DONE && fill_reg == 6'd0))
        else $error("digest shown before padding finished");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD) |=> (round_reg == 7'd0))
        else $error("round counter not cleared after compression");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAD) |-> (pad_reg != PS_NONE && pad_reg != PS_DONE))
        else $error("pad state without pad stage");

endmodule
